[rtl/acmac_pkg.sv]
// ----------------------------------------------------------------------------
// acmac_pkg
// Shared constants, types and AES helper functions for the CMAC engine.
// ----------------------------------------------------------------------------
package acmac_pkg;

  localparam int unsigned MessageBlocks = 2;
  localparam int unsigned BlkIdxW = (MessageBlocks > 1) ? $clog2(MessageBlocks) : 1;
  localparam logic [7:0] CmacReduce = 8'h87;
  localparam logic [3:0] LastRound = 4'd10;

  localparam logic CfgKeyHigh = 1'b0;
  localparam logic CfgKeyLow  = 1'b1;

  typedef logic [127:0] blk_t;

  // request from the sequencer to the round unit
  typedef struct packed {
    logic start;
    blk_t data;
  } aes_req_t;

  typedef struct packed {
    logic done;
    blk_t data;
  } aes_rsp_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block, byte 0 in the top bits
  function automatic logic [7:0] byte_of(input blk_t b, input int i);
    return b[127-8*i -: 8];
  endfunction

endpackage

[rtl/acmac_round.sv]
// ----------------------------------------------------------------------------
// acmac_round
// Shared AES-128 round unit: one round and one key-schedule step a cycle.
// ----------------------------------------------------------------------------
module acmac_round (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [127:0]          key_i,
  input  acmac_pkg::aes_req_t   req_i,
  output acmac_pkg::aes_rsp_t   rsp_o
);

  logic [127:0] state_q, state_d;
  logic [127:0] rkey_q, rkey_d;
  logic [7:0]   rcon_q, rcon_d;
  logic [3:0]   round_q, round_d;
  logic         run_q, run_d;
  logic         done_q, done_d;

  logic [127:0] sub_shift, mixed, next_key;
  logic [31:0]  rot_w;

  // next round key from the current one
  always_comb begin
    rot_w = {acmac_pkg::sbox(rkey_q[23:16]) ^ rcon_q, acmac_pkg::sbox(rkey_q[15:8]),
             acmac_pkg::sbox(rkey_q[7:0]), acmac_pkg::sbox(rkey_q[31:24])};
    next_key[127:96] = rkey_q[127:96] ^ rot_w;
    next_key[95:64]  = rkey_q[95:64] ^ next_key[127:96];
    next_key[63:32]  = rkey_q[63:32] ^ next_key[95:64];
    next_key[31:0]   = rkey_q[31:0] ^ next_key[63:32];
  end

  // SubBytes, ShiftRows and MixColumns
  always_comb begin
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        sub_shift[127-8*(c*4+j) -: 8] =
          acmac_pkg::sbox(acmac_pkg::byte_of(state_q, ((c + j) % 4) * 4 + j));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sub_shift[127-32*c -: 8];
      a1 = sub_shift[119-32*c -: 8];
      a2 = sub_shift[111-32*c -: 8];
      a3 = sub_shift[103-32*c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      mixed[127-32*c -: 8] = a0 ^ all ^ acmac_pkg::xtime(a0 ^ a1);
      mixed[119-32*c -: 8] = a1 ^ all ^ acmac_pkg::xtime(a1 ^ a2);
      mixed[111-32*c -: 8] = a2 ^ all ^ acmac_pkg::xtime(a2 ^ a3);
      mixed[103-32*c -: 8] = a3 ^ all ^ acmac_pkg::xtime(a3 ^ a0);
    end
  end

  // advance one round a cycle
  always_comb begin
    state_d = state_q;
    rkey_d  = rkey_q;
    rcon_d  = rcon_q;
    round_d = round_q;
    run_d   = run_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      state_d = req_i.data ^ key_i;
      rkey_d  = key_i;
      rcon_d  = 8'h01;
      round_d = 4'd1;
      run_d   = 1'b1;
    end else if (run_q) begin
      state_d = ((round_q == acmac_pkg::LastRound) ? sub_shift : mixed) ^ next_key;
      rkey_d  = next_key;
      rcon_d  = acmac_pkg::xtime(rcon_q);
      round_d = round_q + 4'd1;
      if (round_q == acmac_pkg::LastRound) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      done_q  <= 1'b0;
      round_q <= '0;
      rcon_q  <= '0;
    end else begin
      run_q   <= run_d;
      done_q  <= done_d;
      round_q <= round_d;
      rcon_q  <= rcon_d;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    rkey_q  <= rkey_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.data = state_q;

endmodule

[rtl/aes_cmac_two_block.sv]
// Flow: the first word of a message starts the subkey derivation, middle first
// halves are only held, and each second half runs ten rounds of the shared round unit.
// Digest words appear in StOut0 and StOut1 after the last block's rounds finish.
// A new message word is accepted only while idle, not while rounds or output run.
// Reset: asynchronous, active low; clears key, chain, subkey and counters.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// aes_cmac_two_block
// AES-128 CMAC sequencer over a shared round unit.
// ----------------------------------------------------------------------------
module aes_cmac_two_block (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] message_word_i,
  output logic        strobe,
  output logic [63:0] digest_word_o,
  output logic        last_word_o
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StKey   = 5'b00010,
    StBlock = 5'b00100,
    StOut0  = 5'b01000,
    StOut1  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [63:0] key_hi_q, key_lo_q;
  logic [127:0] chain_q, chain_d, k1_q, k1_d;
  logic [63:0] held_q, held_d;
  logic        pos_q, pos_d;
  logic [acmac_pkg::BlkIdxW-1:0] blk_q, blk_d;
  logic        fin_q, fin_d;
  acmac_pkg::aes_req_t req;
  acmac_pkg::aes_rsp_t rsp;
  logic        accept;
  logic [127:0] blk_in;

  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);

  acmac_round u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .key_i  ({key_hi_q, key_lo_q}),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign blk_in = chain_q ^ {held_q, message_word_i} ^
                  ((32'(blk_q) + 32'd1 >= acmac_pkg::MessageBlocks) ? k1_q : '0);

  // sequence words, subkey and blocks
  always_comb begin
    state_d  = state_q;
    chain_d  = chain_q;
    k1_d     = k1_q;
    held_d   = held_q;
    pos_d    = pos_q;
    blk_d    = blk_q;
    fin_d    = fin_q;
    req      = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (!pos_q) begin
            held_d = message_word_i;
            pos_d  = 1'b1;
            if (blk_q == '0) begin
              req.start = 1'b1;
              req.data  = '0;
              state_d   = StKey;
            end
          end else begin
            pos_d     = 1'b0;
            req.start = 1'b1;
            req.data  = blk_in;
            fin_d     = (32'(blk_q) + 32'd1 >= acmac_pkg::MessageBlocks);
            state_d   = StBlock;
          end
        end
      end
      StKey: begin
        if (rsp.done) begin
          k1_d = {rsp.data[126:0], 1'b0} ^
                 {120'd0, (rsp.data[127] ? acmac_pkg::CmacReduce : 8'h00)};
          chain_d = '0;
          state_d = StIdle;
        end
      end
      StBlock: begin
        if (rsp.done) begin
          chain_d = rsp.data;
          if (fin_q) begin
            blk_d   = '0;
            state_d = StOut0;
          end else begin
            blk_d   = blk_q + 1'b1;
            state_d = StIdle;
          end
        end
      end
      StOut0: state_d = StOut1;
      StOut1: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      key_hi_q <= '0;
      key_lo_q <= '0;
      chain_q  <= '0;
      k1_q     <= '0;
      held_q   <= '0;
      pos_q    <= 1'b0;
      blk_q    <= '0;
      fin_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      chain_q <= chain_d;
      k1_q    <= k1_d;
      held_q  <= held_d;
      pos_q   <= pos_d;
      blk_q   <= blk_d;
      fin_q   <= fin_d;
      if (cfg_we_i && cfg_idx_i == acmac_pkg::CfgKeyHigh) key_hi_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == acmac_pkg::CfgKeyLow)  key_lo_q <= cfg_data_i;
    end
  end

  // drive the digest words
  assign strobe        = (state_q == StOut0) || (state_q == StOut1);
  assign last_word_o   = (state_q == StOut1);
  assign digest_word_o = (state_q == StOut1) ? chain_q[63:0] : chain_q[127:64];

endmodule

[rtl/acmac_checker.sv]
// ----------------------------------------------------------------------------
// acmac_checker
// Port-level checks on the CMAC engine.
// ----------------------------------------------------------------------------
module acmac_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic busy,
  input logic strobe,
  input logic last_word_o
);

  // the final word follows the first at once
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && !last_word_o |=> strobe && last_word_o) else $error("digest pair split");

  a_last_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && last_word_o |-> $past(strobe) && !$past(last_word_o))
    else $error("last word without first");

  // no output while idle to accept
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> busy) else $error("strobe while idle");

  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && last_word_o |=> !strobe) else $error("extra digest word");

endmodule

bind aes_cmac_two_block acmac_checker u_acmac_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .busy(busy),
  .strobe(strobe), .last_word_o(last_word_o)
);
